[hdl/hns_pkg.sv]
package hns_pkg;

    localparam int HEIGHT_W    = 16;
    localparam int CFG_W       = 9;
    localparam int CFG_RESET   = 256;
    localparam int MIN_SIDE    = 2;
    localparam int OUT_W       = 24;
    localparam int COORD_W     = 8;
    localparam int OUT_MAX     = 8388607;
    localparam int OUT_MIN_MAG = 8388608;

    typedef enum logic {
        MODE_SAMPLE = 1'b0,
        MODE_FLUSH  = 1'b1
    } mode_t;

    typedef logic [HEIGHT_W-1:0] height_t;

endpackage

[hdl/hns_line_store.sv]
module hns_line_store #(
    parameter int ADDR_W = 9
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [ADDR_W-1:0]     waddr,
    input  hns_pkg::height_t      wdata,
    input  logic [ADDR_W-1:0]     raddr,
    output hns_pkg::height_t      rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    hns_pkg::height_t mem [DEPTH];
    hns_pkg::height_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/hns_divider.sv]
module hns_divider #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 9
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [1:0][NUM_W-1:0] num,
    input  logic [DEN_W-1:0]      den,
    output logic                  busy,
    output logic [1:0][NUM_W-1:0] quot
);

    localparam int LANES  = 2;
    localparam int STEP_W = $clog2(NUM_W + 1);

    logic                  busy_reg;
    logic                  busy_next;
    logic [STEP_W-1:0]     step_reg;
    logic [STEP_W-1:0]     step_next;
    logic [1:0][NUM_W-1:0] quot_reg;
    logic [1:0][DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0]      den_reg;
    logic [1:0][DEN_W:0]   trial;
    logic [1:0][DEN_W:0]   trial_sub;
    logic [1:0]            fits;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            trial[i]     = {rem_reg[i], quot_reg[i][NUM_W-1]};
            fits[i]      = trial[i] >= {1'b0, den_reg};
            trial_sub[i] = trial[i] - {1'b0, den_reg};
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    // while busy, shift one quotient bit per lane per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= num;
            rem_reg  <= '0;
            den_reg  <= den;
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                quot_reg[i] <= {quot_reg[i][NUM_W-2:0], fits[i]};
                rem_reg[i]  <= fits[i] ? trial_sub[i][DEN_W-1:0] : trial[i][DEN_W-1:0];
            end
        end
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

endmodule

[hdl/heightmap_normal_stencil_unit.sv]
// Heightmap normal stencil.
// Height samples enter on the in_valid/in_ready channel in raster order, one
// word per sample (mode 0). Each sample of row r+1 yields the normal of the
// vertex in row r, same column; row 0 yields nothing. Once the whole grid is
// in, flush words (mode 1) drain the last row; the final one carries
// frame_last and starts a new frame. Results leave on out_valid/out_ready.
// grid_side is written through cfg_we/cfg_data; the user must write it only
// while the block is idle, which the block itself does not enforce. A write
// restarts the frame. A word that yields a normal goes from acceptance
// through reads of centre, left, right and down on the single line store
// read port, forming the differences, the bit-serial divider and loading the
// output register, then back to idle to take the next word. Row 0 samples
// and ignored words leave the block in idle, ready for the next word.
// A finished normal waits in the output register while the next word is
// accepted and worked on; the sequencer only holds its own result when the
// register is still full. Reset empties the output register, zeroes the
// counters and sets grid_side to 256; the line store is not cleared.
module heightmap_normal_stencil_unit #(
    parameter int MAX_SIDE  = 256,
    parameter int FRAC_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [hns_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                mode,
    input  logic [hns_pkg::HEIGHT_W-1:0]        height,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [hns_pkg::OUT_W-1:0]    normal_x,
    output logic signed [hns_pkg::OUT_W-1:0]    normal_z,
    output logic [hns_pkg::COORD_W-1:0]         column,
    output logic [hns_pkg::COORD_W-1:0]         row,
    output logic                                frame_last
);

    localparam int HW     = hns_pkg::HEIGHT_W;
    localparam int OUT_W  = hns_pkg::OUT_W;
    localparam int COL_W  = $clog2(MAX_SIDE);
    localparam int CNT_W  = $clog2(MAX_SIDE + 1);
    localparam int ADDR_W = COL_W + 1;
    localparam int NUM_W  = HW + FRAC_BITS;
    localparam int SW     = (CNT_W > hns_pkg::CFG_W) ? CNT_W : hns_pkg::CFG_W;
    localparam int QW     = (NUM_W > OUT_W) ? NUM_W : OUT_W;
    localparam int RD_W   = 3;

    localparam logic [RD_W-1:0] RD_CENTRE = 3'd0;
    localparam logic [RD_W-1:0] RD_LEFT   = 3'd1;
    localparam logic [RD_W-1:0] RD_RIGHT  = 3'd2;
    localparam logic [RD_W-1:0] RD_DOWN   = 3'd3;
    localparam logic [RD_W-1:0] RD_LAST   = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_DIFF = 4'b0100,
        S_DIV  = 4'b1000
    } state_t;

    typedef struct packed {
        logic [COL_W-1:0]  c;
        logic [COL_W-1:0]  r;
        hns_pkg::height_t  h;
        logic              cb;
        logic              flush;
        logic              last;
        logic              has_left;
        logic              has_right;
        logic              has_down;
    } job_t;

    state_t                    state_reg;
    state_t                    state_next;
    logic [RD_W-1:0]           rd_cnt_reg;
    logic [RD_W-1:0]           rd_cnt_next;
    logic [hns_pkg::CFG_W-1:0] grid_side_reg;
    logic [hns_pkg::CFG_W-1:0] grid_side_next;
    logic [COL_W-1:0]          in_column_reg;
    logic [COL_W-1:0]          in_column_next;
    logic [CNT_W-1:0]          in_row_reg;
    logic [CNT_W-1:0]          in_row_next;
    logic [COL_W-1:0]          flush_column_reg;
    logic [COL_W-1:0]          flush_column_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;

    job_t                      job_reg;
    job_t                      job_new;
    hns_pkg::height_t          centre_reg;
    hns_pkg::height_t          left_reg;
    hns_pkg::height_t          right_reg;
    hns_pkg::height_t          down_reg;
    logic [1:0]                neg_reg;
    logic [OUT_W-1:0]          normal_x_reg;
    logic [OUT_W-1:0]          normal_z_reg;
    logic [hns_pkg::COORD_W-1:0] column_reg;
    logic [hns_pkg::COORD_W-1:0] row_reg;
    logic                      frame_last_reg;

    logic [SW-1:0]             side_clamp;
    logic [CNT_W-1:0]          side_used;
    logic                      in_accept;
    logic                      is_flush;
    logic [CNT_W-1:0]          col_ext;
    logic [CNT_W-1:0]          fcol_ext;
    logic                      sample_ok;
    logic                      sample_res;
    logic                      flush_res;
    logic                      flush_last;

    logic                      row0_write;
    logic                      late_write;
    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_waddr;
    hns_pkg::height_t          mem_wdata;
    logic [ADDR_W-1:0]         mem_raddr;
    hns_pkg::height_t          mem_rdata;

    logic [1:0][HW-1:0]        op_a;
    logic [1:0][HW-1:0]        op_b;
    logic [1:0][HW:0]          diff;
    logic [1:0][HW:0]          diff_neg;
    logic [1:0][HW-1:0]        mag;
    logic [1:0][NUM_W-1:0]     div_num;
    logic [1:0][NUM_W-1:0]     div_quot;
    logic                      div_start;
    logic                      div_busy;
    logic [1:0][QW-1:0]        q_ext;
    logic [1:0][QW-1:0]        q_sat;
    logic [1:0][QW-1:0]        q_neg;
    logic [1:0][OUT_W-1:0]     sat_val;
    logic                      out_free;
    logic                      out_load;

    // side in use, clamped to [2, MAX_SIDE]
    always_comb
    begin
        priority if (SW'(grid_side_reg) < SW'(hns_pkg::MIN_SIDE))
        begin
            side_clamp = SW'(hns_pkg::MIN_SIDE);
        end
        else if (SW'(grid_side_reg) > SW'(MAX_SIDE))
        begin
            side_clamp = SW'(MAX_SIDE);
        end
        else
        begin
            side_clamp = SW'(grid_side_reg);
        end
    end

    assign side_used = side_clamp[CNT_W-1:0];

    assign in_ready   = (state_reg == S_IDLE);
    assign in_accept  = in_valid && in_ready;
    assign is_flush   = (mode == hns_pkg::MODE_FLUSH);
    assign col_ext    = CNT_W'(in_column_reg);
    assign fcol_ext   = CNT_W'(flush_column_reg);
    assign sample_ok  = !is_flush && (in_row_reg < side_used) && (col_ext < side_used);
    assign sample_res = sample_ok && (in_row_reg != '0);
    assign flush_res  = is_flush && (in_row_reg == side_used) && (fcol_ext < side_used);
    assign flush_last = (fcol_ext + CNT_W'(1)) == side_used;

    always_comb
    begin
        job_new = '0;
        if (is_flush)
        begin
            job_new.c        = flush_column_reg;
            job_new.r        = COL_W'(side_used - CNT_W'(1));
            job_new.flush    = 1'b1;
            job_new.last     = flush_last;
            job_new.has_down = 1'b1;
        end
        else
        begin
            job_new.c        = in_column_reg;
            job_new.r        = COL_W'(in_row_reg - CNT_W'(1));
            job_new.flush    = 1'b0;
            job_new.last     = 1'b0;
            job_new.has_down = in_row_reg > CNT_W'(1);
        end
        job_new.h         = height;
        job_new.cb        = job_new.r[0];
        job_new.has_left  = job_new.c != '0;
        job_new.has_right = (CNT_W'(job_new.c) + CNT_W'(1)) < side_used;
    end

    // frame counters
    always_comb
    begin
        grid_side_next    = grid_side_reg;
        in_column_next    = in_column_reg;
        in_row_next       = in_row_reg;
        flush_column_next = flush_column_reg;
        priority if (cfg_we)
        begin
            grid_side_next    = cfg_data;
            in_column_next    = '0;
            in_row_next       = '0;
            flush_column_next = '0;
        end
        else if (in_accept && sample_ok)
        begin
            if ((col_ext + CNT_W'(1)) >= side_used)
            begin
                in_column_next = '0;
                in_row_next    = in_row_reg + CNT_W'(1);
            end
            else
            begin
                in_column_next = in_column_reg + COL_W'(1);
            end
        end
        else if (in_accept && flush_res)
        begin
            if (flush_last)
            begin
                in_column_next    = '0;
                in_row_next       = '0;
                flush_column_next = '0;
            end
            else
            begin
                flush_column_next = flush_column_reg + COL_W'(1);
            end
        end
        else
        begin
            grid_side_next = grid_side_reg;
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign out_load = (state_reg == S_DIV) && !div_busy && out_free;

    always_comb
    begin
        state_next  = state_reg;
        rd_cnt_next = rd_cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (sample_res || flush_res))
                begin
                    state_next  = S_READ;
                    rd_cnt_next = RD_CENTRE;
                end
            end
            S_READ:
            begin
                if (rd_cnt_reg == RD_LAST)
                begin
                    state_next = S_DIFF;
                end
                else
                begin
                    rd_cnt_next = rd_cnt_reg + RD_W'(1);
                end
            end
            S_DIFF:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            rd_cnt_reg       <= RD_CENTRE;
            grid_side_reg    <= hns_pkg::CFG_W'(hns_pkg::CFG_RESET);
            in_column_reg    <= '0;
            in_row_reg       <= '0;
            flush_column_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            rd_cnt_reg       <= rd_cnt_next;
            grid_side_reg    <= grid_side_next;
            in_column_reg    <= in_column_next;
            in_row_reg       <= in_row_next;
            flush_column_reg <= flush_column_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // line store access: one read per cycle in S_READ, write after the reads
    always_comb
    begin
        unique case (rd_cnt_reg)
            RD_CENTRE: mem_raddr = {job_reg.cb, job_reg.c};
            RD_LEFT:   mem_raddr = {job_reg.cb, job_reg.c - COL_W'(1)};
            RD_RIGHT:  mem_raddr = {job_reg.cb, job_reg.c + COL_W'(1)};
            RD_DOWN:   mem_raddr = {~job_reg.cb, job_reg.c};
            default:   mem_raddr = {job_reg.cb, job_reg.c};
        endcase
    end

    assign row0_write = in_accept && sample_ok && (in_row_reg == '0);
    assign late_write = (state_reg == S_READ) && (rd_cnt_reg == RD_LAST) && !job_reg.flush;
    assign mem_we     = row0_write || late_write;
    assign mem_waddr  = row0_write ? {1'b0, in_column_reg} : {~job_reg.cb, job_reg.c};
    assign mem_wdata  = row0_write ? height : job_reg.h;

    hns_line_store #(
        .ADDR_W (ADDR_W)
    ) u_line_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // substitute the centre for missing neighbours
    always_comb
    begin
        op_a[0] = job_reg.has_left  ? left_reg  : centre_reg;
        op_b[0] = job_reg.has_right ? right_reg : centre_reg;
        op_a[1] = job_reg.flush     ? centre_reg : job_reg.h;
        op_b[1] = job_reg.has_down  ? down_reg  : centre_reg;
        for (int i = 0; i < 2; i++)
        begin
            diff[i]     = {1'b0, op_a[i]} - {1'b0, op_b[i]};
            diff_neg[i] = (HW + 1)'(0) - diff[i];
            mag[i]      = diff[i][HW] ? diff_neg[i][HW-1:0] : diff[i][HW-1:0];
            div_num[i]  = NUM_W'(mag[i]) << FRAC_BITS;
        end
    end

    assign div_start = (state_reg == S_DIFF);

    hns_divider #(
        .NUM_W (NUM_W),
        .DEN_W (CNT_W)
    ) u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (side_used),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    // saturate to the signed output range
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            q_ext[i] = QW'(div_quot[i]);
            if (neg_reg[i])
            begin
                q_sat[i] = (q_ext[i] > QW'(hns_pkg::OUT_MIN_MAG)) ?
                           QW'(hns_pkg::OUT_MIN_MAG) : q_ext[i];
            end
            else
            begin
                q_sat[i] = (q_ext[i] > QW'(hns_pkg::OUT_MAX)) ?
                           QW'(hns_pkg::OUT_MAX) : q_ext[i];
            end
            q_neg[i]   = QW'(0) - q_sat[i];
            sat_val[i] = neg_reg[i] ? q_neg[i][OUT_W-1:0] : q_sat[i][OUT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            job_reg <= job_new;
        end
        if (state_reg == S_READ)
        begin
            unique case (rd_cnt_reg)
                RD_LEFT:  centre_reg <= mem_rdata;
                RD_RIGHT: left_reg   <= mem_rdata;
                RD_DOWN:  right_reg  <= mem_rdata;
                RD_LAST:  down_reg   <= mem_rdata;
                default:  centre_reg <= centre_reg;
            endcase
        end
        if (state_reg == S_DIFF)
        begin
            neg_reg <= {diff[1][HW], diff[0][HW]};
        end
        if (out_load)
        begin
            normal_x_reg   <= sat_val[0];
            normal_z_reg   <= sat_val[1];
            column_reg     <= hns_pkg::COORD_W'(job_reg.c);
            row_reg        <= hns_pkg::COORD_W'(job_reg.r);
            frame_last_reg <= job_reg.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign normal_x   = $signed(normal_x_reg);
    assign normal_z   = $signed(normal_z_reg);
    assign column     = column_reg;
    assign row        = row_reg;
    assign frame_last = frame_last_reg;

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_row_reg <= side_used)
        else $error("row counter beyond grid side");

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(in_column_reg) < side_used)
        else $error("column counter beyond grid side");

    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_IDLE || state_reg == S_READ))
        else $error("line store written outside idle or read phase");

    a_div_phase: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == S_DIV))
        else $error("divider running outside divide phase");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && flush_res && flush_last) |=>
        (in_row_reg == '0 && in_column_reg == '0 && flush_column_reg == '0))
        else $error("counters not cleared after final flush word");

endmodule
